// File: design/fct_pkg.sv
`default_nettype none

package fct_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int NORMAL_WIDTH = 12;
  localparam int NORMAL_FRAC  = 10;
  localparam int NUM_PLANES   = 6;
  localparam int CFG_IDX_W    = $clog2(NUM_PLANES);
  localparam int PLANE_W      = 64;
  localparam int OFFSET_W     = PLANE_W - 3 * NORMAL_WIDTH;
  localparam int RAD_W        = COORD_WIDTH - 1;
  localparam int PROD_W       = NORMAL_WIDTH + COORD_WIDTH;

  // widest of the terms that meet in one distance sum, plus headroom for the adds
  localparam int SUM_A = (PROD_W + 2 > OFFSET_W + NORMAL_FRAC) ?
                         (PROD_W + 2) : (OFFSET_W + NORMAL_FRAC);
  localparam int SUM_B = (SUM_A > RAD_W + NORMAL_FRAC + 1) ? SUM_A : (RAD_W + NORMAL_FRAC + 1);
  localparam int SUM_W = SUM_B + 2;

  localparam int IN_DATA_BITS = 9 * COORD_WIDTH + RAD_W;
  localparam int IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int VIS_W        = 2;
  localparam int OUT_TDATA_W  = ((VIS_W + 7) / 8) * 8;

  typedef enum logic [VIS_W-1:0] {
    VIS_OUTSIDE   = 2'd0,
    VIS_INTERSECT = 2'd1,
    VIS_INSIDE    = 2'd2
  } vis_t;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [NORMAL_WIDTH-1:0] norm_t;
  typedef logic signed [OFFSET_W-1:0]     offset_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic [RAD_W-1:0]               rad_t;

  // matches the register layout: nx in the low bits, offset on top
  typedef struct packed {
    offset_t d;
    norm_t   nz;
    norm_t   ny;
    norm_t   nx;
  } plane_t;

  typedef struct packed {
    logic         op;
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    coord_t [2:0] ctr;
    rad_t         rad;
  } item_t;

  typedef struct packed {
    logic                             op;
    rad_t                             rad;
    prod_t [NUM_PLANES-1:0][2:0]      pp;
    prod_t [NUM_PLANES-1:0][2:0]      np;
  } prod_item_t;

  typedef struct packed {
    sum_t [NUM_PLANES-1:0] psum;
    sum_t [NUM_PLANES-1:0] nsum;
    sum_t [NUM_PLANES-1:0] pbias;
    sum_t [NUM_PLANES-1:0] nbias;
  } sum_item_t;

endpackage

`default_nettype wire

// File: design/fct_mul.sv
`default_nettype none

module fct_mul (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire fct_pkg::item_t                              in_item,
  input  wire fct_pkg::plane_t [fct_pkg::NUM_PLANES-1:0]   planes,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output fct_pkg::prod_item_t                              out_item
);
  import fct_pkg::*;

  logic       valid_r;
  prod_item_t item_r;
  prod_item_t item_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    norm_t [2:0] nrm;
    coord_t      pc;
    coord_t      nc;
    item_nxt     = '0;
    item_nxt.op  = in_item.op;
    item_nxt.rad = in_item.rad;
    for (int i = 0; i < NUM_PLANES; i++) begin
      nrm = {planes[i].nz, planes[i].ny, planes[i].nx};
      for (int k = 0; k < 3; k++) begin
        // box: far corner along the normal; a zero component picks the max side; sphere: its center
        if (in_item.op) begin
          pc = in_item.ctr[k];
          nc = in_item.ctr[k];
        end else if (!nrm[k][NORMAL_WIDTH-1]) begin
          pc = in_item.hi[k];
          nc = in_item.lo[k];
        end else begin
          pc = in_item.lo[k];
          nc = in_item.hi[k];
        end
        item_nxt.pp[i][k] = prod_t'($signed(nrm[k])) * prod_t'($signed(pc));
        item_nxt.np[i][k] = prod_t'($signed(nrm[k])) * prod_t'($signed(nc));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/fct_sum.sv
`default_nettype none

module fct_sum (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire fct_pkg::prod_item_t                         in_item,
  input  wire fct_pkg::plane_t [fct_pkg::NUM_PLANES-1:0]   planes,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output fct_pkg::sum_item_t                               out_item
);
  import fct_pkg::*;

  logic      valid_r;
  sum_item_t item_r;
  sum_item_t item_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    sum_t radx;
    sum_t dext;
    // box test compares against zero, sphere test against +/- radius
    radx = in_item.op ? (sum_t'(in_item.rad) <<< NORMAL_FRAC) : '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      dext = sum_t'(planes[i].d) <<< NORMAL_FRAC;
      item_nxt.psum[i]  = sum_t'(in_item.pp[i][0]) + sum_t'(in_item.pp[i][1])
                        + sum_t'(in_item.pp[i][2]);
      item_nxt.nsum[i]  = sum_t'(in_item.np[i][0]) + sum_t'(in_item.np[i][1])
                        + sum_t'(in_item.np[i][2]);
      item_nxt.pbias[i] = dext + radx;
      item_nxt.nbias[i] = dext - radx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/fct_vote.sv
`default_nettype none

module fct_vote (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fct_pkg::sum_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fct_pkg::vis_t           out_vis
);
  import fct_pkg::*;

  logic valid_r;
  vis_t vis_r;
  vis_t vis_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_vis   = vis_r;

  always_comb begin
    logic [NUM_PLANES-1:0] behind_p;
    logic [NUM_PLANES-1:0] behind_n;
    sum_t                  dp;
    sum_t                  dn;
    for (int i = 0; i < NUM_PLANES; i++) begin
      dp          = in_item.psum[i] + in_item.pbias[i];
      dn          = in_item.nsum[i] + in_item.nbias[i];
      behind_p[i] = dp[SUM_W-1];
      behind_n[i] = dn[SUM_W-1];
    end
    if (|behind_p) begin
      vis_nxt = VIS_OUTSIDE;
    end else if (|behind_n) begin
      vis_nxt = VIS_INTERSECT;
    end else begin
      vis_nxt = VIS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      vis_r <= vis_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/frustum_cull_test.sv
// Frustum cull test: classifies an axis-aligned box (tuser 0) or a sphere (tuser 1)
// against six planes written over the cfg port (index 0..5: left, right, bottom,
// top, near, far; each 64 bits: nx, ny, nz as signed 12-bit value/1024 from bit 0
// up, signed 28-bit offset in coordinate units on top). The result is 0 outside,
// 1 intersecting, 2 fully inside. One beat is taken per clock unless stalled; a
// result passes the input register, multiply, sum, and compare and vote stages,
// with all 36 products of the six planes formed in parallel in one stage.
// Each stage holds its own beat and backpressure only stops stages that are full.
// Planes may be rewritten only while the pipeline is empty.
`default_nettype none

module frustum_cull_test (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, center_x, center_y, center_z, radius
  input  wire logic [fct_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // visibility
  output logic [fct_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [fct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fct_pkg::PLANE_W-1:0]        cfg_wdata
);
  import fct_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [PLANE_W-1:0]             plane_r [NUM_PLANES];
  plane_t [NUM_PLANES-1:0]        planes;

  logic       s0_valid_r;
  item_t      s0_item_r;
  item_t      in_item;
  logic       mul_ready;
  logic       mul_valid;
  prod_item_t mul_item;
  logic       sum_ready;
  logic       sum_valid;
  sum_item_t  sum_item;
  logic       vote_ready;
  vis_t       vis;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          plane_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      planes[i] = plane_t'(plane_r[i]);
    end
  end

  // unpack the beat, fields from the low bits up
  always_comb begin
    in_item.op = in_tuser;
    for (int k = 0; k < 3; k++) begin
      in_item.lo[k]  = in_tdata[k*CW +: CW];
      in_item.hi[k]  = in_tdata[(3+k)*CW +: CW];
      in_item.ctr[k] = in_tdata[(6+k)*CW +: CW];
    end
    in_item.rad = in_tdata[9*CW +: RAD_W];
  end

  assign in_tready = !s0_valid_r || mul_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_item_r <= in_item;
    end
  end

  fct_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_ready  (mul_ready),
    .in_item   (s0_item_r),
    .planes    (planes),
    .out_valid (mul_valid),
    .out_ready (sum_ready),
    .out_item  (mul_item)
  );

  fct_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (sum_ready),
    .in_item   (mul_item),
    .planes    (planes),
    .out_valid (sum_valid),
    .out_ready (vote_ready),
    .out_item  (sum_item)
  );

  fct_vote u_vote (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_ready  (vote_ready),
    .in_item   (sum_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_vis   (vis)
  );

  assign out_tdata = OUT_TDATA_W'(vis);

endmodule

`default_nettype wire
